@@ rtl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Shared helpers for concurrent checks, sampled on the rising clock edge and
// disabled while the synchronous active-low reset is held.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every sampled edge outside reset.
`define ASSERT_ALWAYS(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error(msg);

// When the trigger holds, the consequence must hold in the same cycle.
`define ASSERT_IMPL(label, clk, rstn, trig, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (trig) |-> (cons)) \
        else $error(msg);

// When the trigger holds, the consequence must hold in the next cycle.
`define ASSERT_NEXT(label, clk, rstn, trig, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (trig) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/lss_pkg.sv @@
// ---------------------------------------------------------------------------
// lss_pkg
// Shared constants, codes and types of the LIFO stack with search.
// ---------------------------------------------------------------------------
package lss_pkg;

    localparam int STACK_DEPTH = 128;
    localparam int WORD_W      = 32;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int DEPTH_W     = 8;
    localparam int CMD_W       = 2;
    localparam int STATUS_W    = 2;

    localparam logic [CMD_W-1:0] CMD_PUSH   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_POP    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } state_t;

    // Shift commands broadcast to every cell of the chain.
    typedef struct packed {
        logic push;
        logic pop;
    } cell_ctl_t;

endpackage

@@ rtl/lss_cell.sv @@
// ---------------------------------------------------------------------------
// lss_cell
// One stack entry: shifts with its neighbors on push and pop, and passes the
// search token and the running match bit on to the next cell.
// ---------------------------------------------------------------------------
module lss_cell (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  lss_pkg::cell_ctl_t                 ctl,
    input  logic                               occupied,
    input  logic signed [lss_pkg::WORD_W-1:0]  word_up,
    input  logic signed [lss_pkg::WORD_W-1:0]  word_dn,
    input  logic signed [lss_pkg::WORD_W-1:0]  key,
    input  logic                               tok_in,
    input  logic                               hit_in,
    output logic signed [lss_pkg::WORD_W-1:0]  word,
    output logic                               tok_out,
    output logic                               hit_out
);

    logic signed [lss_pkg::WORD_W-1:0] word_reg;
    logic signed [lss_pkg::WORD_W-1:0] word_next;
    logic                              tok_reg;
    logic                              hit_reg;
    logic                              hit_next;

    always_comb begin
        priority if (ctl.push) begin
            word_next = word_up;
        end else if (ctl.pop) begin
            word_next = word_dn;
        end else begin
            word_next = word_reg;
        end
    end

    // Only entries below the fill count take part in a search.
    assign hit_next = hit_in | (tok_in & occupied & (word_reg == key));

    always_ff @(posedge aclk) begin
        word_reg <= word_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg <= 1'b0;
            hit_reg <= 1'b0;
        end else begin
            tok_reg <= tok_in;
            hit_reg <= hit_next;
        end
    end

    assign word    = word_reg;
    assign tok_out = tok_reg;
    assign hit_out = hit_reg;

endmodule

@@ rtl/lss_ctrl.sv @@
// ---------------------------------------------------------------------------
// lss_ctrl
// Command decode, fill count, search sequencing and the result register.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module lss_ctrl (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [lss_pkg::CMD_W-1:0]            s_command,
    input  logic signed [lss_pkg::WORD_W-1:0]    s_value,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [lss_pkg::STATUS_W-1:0]         m_status,
    output logic signed [lss_pkg::WORD_W-1:0]    m_data,
    output logic                                 m_found,
    output logic [lss_pkg::DEPTH_W-1:0]          m_depth,
    output lss_pkg::cell_ctl_t                   cell_ctl,
    output logic signed [lss_pkg::WORD_W-1:0]    key,
    output logic                                 start,
    output logic [lss_pkg::CNT_W-1:0]            count,
    input  logic signed [lss_pkg::WORD_W-1:0]    top_word,
    input  logic                                 tok_last,
    input  logic                                 hit_last
);

    lss_pkg::state_t                     state_reg;
    lss_pkg::state_t                     state_next;
    logic [lss_pkg::CNT_W-1:0]           count_reg;
    logic [lss_pkg::CNT_W-1:0]           count_next;
    logic signed [lss_pkg::WORD_W-1:0]   key_reg;
    logic                                start_reg;
    logic                                m_valid_reg;
    logic [lss_pkg::STATUS_W-1:0]        status_reg;
    logic [lss_pkg::STATUS_W-1:0]        status_next;
    logic signed [lss_pkg::WORD_W-1:0]   data_reg;
    logic                                found_reg;
    logic [lss_pkg::DEPTH_W-1:0]         depth_reg;

    logic accept;
    logic is_full;
    logic is_empty;
    logic push_ok;
    logic pop_ok;
    logic search_acc;
    logic load_direct;

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            lss_pkg::ST_IDLE: begin
                if (search_acc) begin
                    state_next = lss_pkg::ST_SCAN;
                end
            end
            lss_pkg::ST_SCAN: begin
                if (tok_last) begin
                    state_next = lss_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = lss_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs of the state machine.
    always_comb begin
        unique case (state_reg)
            lss_pkg::ST_IDLE: s_ready = !m_valid_reg || m_ready;
            lss_pkg::ST_SCAN: s_ready = 1'b0;
            default:          s_ready = 1'b0;
        endcase
    end

    assign accept      = s_valid && s_ready;
    assign is_full     = (count_reg == lss_pkg::CNT_W'(lss_pkg::STACK_DEPTH));
    assign is_empty    = (count_reg == '0);
    assign push_ok     = accept && (s_command == lss_pkg::CMD_PUSH) && !is_full;
    assign pop_ok      = accept && (s_command == lss_pkg::CMD_POP) && !is_empty;
    assign search_acc  = accept && (s_command == lss_pkg::CMD_SEARCH);
    assign load_direct = accept && (s_command != lss_pkg::CMD_SEARCH);

    always_comb begin
        count_next = count_reg;
        if (push_ok) begin
            count_next = count_reg + 1'b1;
        end else if (pop_ok) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_comb begin
        status_next = lss_pkg::STATUS_OK;
        if ((s_command == lss_pkg::CMD_PUSH) && is_full) begin
            status_next = lss_pkg::STATUS_FULL;
        end else if ((s_command == lss_pkg::CMD_POP) && is_empty) begin
            status_next = lss_pkg::STATUS_EMPTY;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= lss_pkg::ST_IDLE;
            count_reg   <= '0;
            start_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            start_reg <= search_acc;
            if (load_direct || tok_last) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (search_acc) begin
            key_reg <= s_value;
        end
        if (load_direct) begin
            status_reg <= status_next;
            data_reg   <= pop_ok ? top_word : '0;
            found_reg  <= 1'b0;
            depth_reg  <= lss_pkg::DEPTH_W'(count_next);
        end else if (tok_last) begin
            status_reg <= lss_pkg::STATUS_OK;
            data_reg   <= '0;
            found_reg  <= hit_last;
            depth_reg  <= lss_pkg::DEPTH_W'(count_reg);
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_status = status_reg;
    assign m_data   = data_reg;
    assign m_found  = found_reg;
    assign m_depth  = depth_reg;
    assign cell_ctl = '{push: push_ok, pop: pop_ok};
    assign key      = key_reg;
    assign start    = start_reg;
    assign count    = count_reg;

    `ASSERT_ALWAYS(a_count_bound, aclk, aresetn, count_reg <= lss_pkg::CNT_W'(lss_pkg::STACK_DEPTH), "fill count above stack depth")
    `ASSERT_IMPL(a_tok_in_scan, aclk, aresetn, tok_last, state_reg == lss_pkg::ST_SCAN, "search token left the chain outside a scan")
    `ASSERT_IMPL(a_scan_out_free, aclk, aresetn, state_reg == lss_pkg::ST_SCAN, !m_valid_reg, "result register occupied during a scan")
    `ASSERT_NEXT(a_push_count, aclk, aresetn, push_ok, count_reg == $past(count_reg) + 1'b1, "push did not advance the fill count")

endmodule

@@ rtl/lifo_stack_with_search.sv @@
// Push/pop/unused: result in the cycle after the beat; one beat per cycle if m_ready.
// Search: a token walks the cell chain one cell per cycle, through the start register
// and then every cell, and the input is held off until the result is registered.
// The result register lets the next beat enter in the cycle its result is taken.
// Reset (aresetn low, synchronous) empties the stack and clears the result valid.
// ---------------------------------------------------------------------------
// lifo_stack_with_search
// Bounded LIFO stack of signed words kept in a shifting chain of cells, with
// push, pop and a search for a stored value.
// ---------------------------------------------------------------------------
module lifo_stack_with_search (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [lss_pkg::CMD_W-1:0]            s_command,
    input  logic signed [lss_pkg::WORD_W-1:0]    s_value,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [lss_pkg::STATUS_W-1:0]         m_status,
    output logic signed [lss_pkg::WORD_W-1:0]    m_data,
    output logic                                 m_found,
    output logic [lss_pkg::DEPTH_W-1:0]          m_depth
);

    lss_pkg::cell_ctl_t                 cell_ctl;
    logic signed [lss_pkg::WORD_W-1:0]  key;
    logic                               start;
    logic [lss_pkg::CNT_W-1:0]          count;
    logic signed [lss_pkg::WORD_W-1:0]  word [lss_pkg::STACK_DEPTH];
    logic                               tok  [lss_pkg::STACK_DEPTH];
    logic                               hit  [lss_pkg::STACK_DEPTH];

    lss_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_command (s_command),
        .s_value   (s_value),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_status  (m_status),
        .m_data    (m_data),
        .m_found   (m_found),
        .m_depth   (m_depth),
        .cell_ctl  (cell_ctl),
        .key       (key),
        .start     (start),
        .count     (count),
        .top_word  (word[0]),
        .tok_last  (tok[lss_pkg::STACK_DEPTH-1]),
        .hit_last  (hit[lss_pkg::STACK_DEPTH-1])
    );

    // Cell 0 holds the top of the stack; deeper entries sit further down the chain.
    for (genvar i = 0; i < lss_pkg::STACK_DEPTH; i++) begin : g_cell
        logic signed [lss_pkg::WORD_W-1:0] up_w;
        logic signed [lss_pkg::WORD_W-1:0] dn_w;
        logic                              tok_w;
        logic                              hit_w;
        logic                              occ_w;

        if (i == 0) begin : g_head
            assign up_w  = s_value;
            assign tok_w = start;
            assign hit_w = 1'b0;
        end else begin : g_body
            assign up_w  = word[i-1];
            assign tok_w = tok[i-1];
            assign hit_w = hit[i-1];
        end

        if (i == lss_pkg::STACK_DEPTH - 1) begin : g_tail
            assign dn_w = word[i];
        end else begin : g_inner
            assign dn_w = word[i+1];
        end

        assign occ_w = (count > lss_pkg::CNT_W'(i));

        lss_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctl      (cell_ctl),
            .occupied (occ_w),
            .word_up  (up_w),
            .word_dn  (dn_w),
            .key      (key),
            .tok_in   (tok_w),
            .hit_in   (hit_w),
            .word     (word[i]),
            .tok_out  (tok[i]),
            .hit_out  (hit[i])
        );
    end

endmodule

@@ bench/tb.sv @@
// ---------------------------------------------------------------------------
// tb - LIFO stack with search
// Drives push, pop, search and unused command beats into the stack under
// random source gaps and sink stalls. A queue-based model of the stack
// predicts each result, and every result beat is compared field by field
// against the oldest prediction.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

    localparam logic [lss_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS  = 2000;
    localparam int DRAIN_CYCLES  = 200000;
    localparam int SETTLE_CYCLES = lss_pkg::STACK_DEPTH + 8;
    localparam int MAX_REPORTS   = 10;

    typedef struct {
        logic [lss_pkg::STATUS_W-1:0]      status;
        logic signed [lss_pkg::WORD_W-1:0] data;
        logic                              found;
        logic [lss_pkg::DEPTH_W-1:0]       depth;
    } stack_result_t;

    logic                              aclk      = 1'b0;
    logic                              aresetn   = 1'b0;
    logic                              s_valid   = 1'b0;
    logic                              s_ready;
    logic [lss_pkg::CMD_W-1:0]         s_command = lss_pkg::CMD_PUSH;
    logic signed [lss_pkg::WORD_W-1:0] s_value   = '0;
    logic                              m_valid;
    logic                              m_ready   = 1'b0;
    logic [lss_pkg::STATUS_W-1:0]      m_status;
    logic signed [lss_pkg::WORD_W-1:0] m_data;
    logic                              m_found;
    logic [lss_pkg::DEPTH_W-1:0]       m_depth;

    // Model of the stack contents, bottom entry first.
    logic signed [lss_pkg::WORD_W-1:0] stack_words[$];
    stack_result_t                     pending_results[$];

    int mismatch_count = 0;
    int items_sent     = 0;
    int burst_left     = 0;

    lifo_stack_with_search u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_command (s_command),
        .s_value   (s_value),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_status  (m_status),
        .m_data    (m_data),
        .m_found   (m_found),
        .m_depth   (m_depth)
    );

    always #5 aclk = ~aclk;

    initial begin
        #20_000_000;
        $display("FAILURE");
        $finish;
    end

    function automatic stack_result_t apply_command(
        logic [lss_pkg::CMD_W-1:0] cmd,
        logic signed [lss_pkg::WORD_W-1:0] val);
        stack_result_t r;
        r.status = lss_pkg::STATUS_OK;
        r.data   = '0;
        r.found  = 1'b0;
        if (cmd == lss_pkg::CMD_PUSH) begin
            if (stack_words.size() >= lss_pkg::STACK_DEPTH)
                r.status = lss_pkg::STATUS_FULL;
            else
                stack_words.push_back(val);
        end else if (cmd == lss_pkg::CMD_POP) begin
            if (stack_words.size() == 0)
                r.status = lss_pkg::STATUS_EMPTY;
            else
                r.data = stack_words.pop_back();
        end else if (cmd == lss_pkg::CMD_SEARCH) begin
            foreach (stack_words[i])
                if (stack_words[i] == val)
                    r.found = 1'b1;
        end
        r.depth = lss_pkg::DEPTH_W'(stack_words.size());
        return r;
    endfunction

    task automatic note_mismatch(string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("%0t mismatch: %s", $realtime, msg);
    endtask

    // Sends one beat; the source may idle between bursts of random length.
    task automatic send_item(logic [lss_pkg::CMD_W-1:0] cmd,
                             logic signed [lss_pkg::WORD_W-1:0] val);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                @(negedge aclk);
                s_valid   <= 1'b0;
                s_command <= lss_pkg::CMD_W'($urandom);
                s_value   <= $urandom;
                repeat (gap - 1) @(negedge aclk);
            end
        end
        burst_left--;
        @(negedge aclk);
        s_valid   <= 1'b1;
        s_command <= cmd;
        s_value   <= val;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_results.push_back(apply_command(cmd, val));
        items_sent++;
    endtask

    function automatic logic signed [lss_pkg::WORD_W-1:0] extreme_word();
        case ($urandom_range(0, 3))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7FFF_FFFF;
            2:       return 32'sd0;
            default: return -32'sd1;
        endcase
    endfunction

    // Small values make duplicates common, so searches hit more often.
    function automatic logic signed [lss_pkg::WORD_W-1:0] pick_value(
        logic [lss_pkg::CMD_W-1:0] cmd);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (cmd == lss_pkg::CMD_SEARCH && roll < 50 && stack_words.size() != 0)
            return stack_words[$urandom_range(0, stack_words.size() - 1)];
        if (cmd == lss_pkg::CMD_PUSH || cmd == lss_pkg::CMD_SEARCH) begin
            if (roll < 75)
                return int'($urandom_range(0, 8)) - 4;
            if (roll < 85)
                return extreme_word();
        end
        return $urandom;
    endfunction

    task automatic send_random_op(int unsigned push_w, int unsigned pop_w);
        int unsigned               roll;
        logic [lss_pkg::CMD_W-1:0] cmd;
        roll = $urandom_range(0, 99);
        if (roll < push_w)
            cmd = lss_pkg::CMD_PUSH;
        else if (roll < push_w + pop_w)
            cmd = lss_pkg::CMD_POP;
        else if (roll < 96)
            cmd = lss_pkg::CMD_SEARCH;
        else
            cmd = CMD_UNUSED;
        send_item(cmd, pick_value(cmd));
    endtask

    task automatic test_empty_stack();
        send_item(lss_pkg::CMD_POP, 32'sh7FFF_FFFF);
        send_item(lss_pkg::CMD_SEARCH, 32'sd0);
        send_item(CMD_UNUSED, 32'sh8000_0000);
    endtask

    task automatic test_word_extremes();
        logic signed [lss_pkg::WORD_W-1:0] words[5];
        words = '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sd0, -32'sd1, 32'sd100};
        foreach (words[i])
            send_item(lss_pkg::CMD_PUSH, words[i]);
        foreach (words[i])
            send_item(lss_pkg::CMD_SEARCH, words[i]);
        send_item(lss_pkg::CMD_SEARCH, 32'sd1);
        send_item(CMD_UNUSED, -32'sd1);
        foreach (words[i])
            send_item(lss_pkg::CMD_POP, $urandom);
        send_item(lss_pkg::CMD_POP, 32'sd0);
    endtask

    // Phases fill the stack past full, drain it past empty, or mix evenly.
    task automatic test_random_traffic();
        int tail;
        int len;
        while (items_sent < RANDOM_ITEMS) begin
            tail = 0;
            case ($urandom_range(0, 2))
                0: while (tail < 8) begin
                    send_random_op(75, 12);
                    if (stack_words.size() == lss_pkg::STACK_DEPTH)
                        tail++;
                end
                1: while (tail < 8) begin
                    send_random_op(12, 75);
                    if (stack_words.size() == 0)
                        tail++;
                end
                default: begin
                    len = $urandom_range(30, 150);
                    repeat (len) send_random_op(40, 40);
                end
            endcase
        end
    endtask

    // Sink readiness follows a randomly re-chosen mode: always ready, ready at random, or ready once per period.
    int unsigned sink_mode  = 0;
    int unsigned sink_left  = 0;
    int unsigned sink_count = 0;
    int unsigned sink_period = 4;

    always @(negedge aclk) begin
        if (sink_left == 0) begin
            sink_mode   = $urandom_range(0, 2);
            sink_left   = $urandom_range(20, 200);
            sink_period = $urandom_range(2, 20);
        end
        sink_left--;
        sink_count++;
        case (sink_mode)
            0:       m_ready <= 1'b1;
            1:       m_ready <= ($urandom_range(0, 3) != 0);
            default: m_ready <= ((sink_count % sink_period) == 0);
        endcase
    end

    always @(posedge aclk) begin : check_results
        stack_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                note_mismatch($sformatf(
                    "result beat with nothing pending: status %0d data %0d found %0b depth %0d",
                    m_status, m_data, m_found, m_depth));
            end else begin
                want = pending_results.pop_front();
                if (m_status !== want.status || m_data !== want.data ||
                    m_found !== want.found || m_depth !== want.depth)
                    note_mismatch($sformatf({
                        "expected status %0d data %0d found %0b depth %0d, ",
                        "got status %0d data %0d found %0b depth %0d"},
                        want.status, want.data, want.found, want.depth,
                        m_status, m_data, m_found, m_depth));
            end
        end
    end

    initial begin
        int waited;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_empty_stack();
        test_word_extremes();
        test_random_traffic();

        @(negedge aclk);
        s_valid <= 1'b0;

        waited = 0;
        while (pending_results.size() != 0 && waited < DRAIN_CYCLES) begin
            @(posedge aclk);
            waited++;
        end
        if (pending_results.size() != 0)
            note_mismatch($sformatf("%0d results never arrived", pending_results.size()));
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/lss_pkg.sv
rtl/lss_cell.sv
rtl/lss_ctrl.sv
rtl/lifo_stack_with_search.sv
bench/tb.sv
